// ----- rtl/pse_pkg.sv -----
// Shared constants and types for the postfix stack evaluator.
`default_nettype none

package pse_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2,
		OP_MUL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/postfix_stack_evaluator_top.sv -----
// Postfix stack evaluator: cached top entries over a stack memory, with an output register.
// A word that ends an expression shows its result on value/status in the cycle after it is
// accepted, held in the output register until taken.
// Throughput: one word per cycle unless a result waits untaken, set by the two-read-port stack
// memory prefetching the two entries below cached top and next; up to two pops a word refill at once.
// Reset clears the stack count, the pending error and the output valid; the stack memory
// keeps its contents and needs no clearing pass, as only entries below the count are used.
`default_nettype none

module postfix_stack_evaluator_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire pse_pkg::op_t                          op,
	input  wire logic signed [pse_pkg::DATA_WIDTH-1:0] number,
	input  wire logic                                  end_of_expr,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [pse_pkg::DATA_WIDTH-1:0]      value,
	output pse_pkg::status_t                           status
);

	import pse_pkg::*;

	// Control state
	logic [CNT_W-1:0]      count_q;
	status_t               err_q;
	logic                  out_valid_q;
	logic                  hit3_q;
	logic                  hit4_q;

	// Payload registers
	logic [DATA_WIDTH-1:0] top_q;
	logic [DATA_WIDTH-1:0] next_q;
	logic [DATA_WIDTH-1:0] fwd_q;
	logic [DATA_WIDTH-1:0] value_q;
	status_t               status_q;

	// Memory interface
	logic [DATA_WIDTH-1:0] rd3;
	logic [DATA_WIDTH-1:0] rd4;
	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [ADDR_W-1:0]     raddr3;
	logic [ADDR_W-1:0]     raddr4;
	logic [CNT_W-1:0]      waddr_full;
	logic [CNT_W-1:0]      raddr3_full;
	logic [CNT_W-1:0]      raddr4_full;

	// Token evaluation
	logic                  accept;
	logic                  full;
	logic                  has2;
	logic [DATA_WIDTH-1:0] t2;
	logic [DATA_WIDTH-1:0] t3;
	logic [DATA_WIDTH-1:0] op_res;
	logic [DATA_WIDTH-1:0] a_top;
	logic [DATA_WIDTH-1:0] a_next;
	logic [DATA_WIDTH-1:0] a_t2;
	logic [CNT_W-1:0]      cnt1;
	status_t               err1;
	logic [CNT_W-1:0]      cnt_n;
	logic [DATA_WIDTH-1:0] top_n;
	logic [DATA_WIDTH-1:0] next_n;
	logic                  emit_empty;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	assign full = (count_q == CNT_W'(STACK_DEPTH));
	assign has2 = (count_q >= CNT_W'(2));

	// Take the entries below next from memory, or the word written last cycle
	assign t2 = hit3_q ? fwd_q : rd3;
	assign t3 = hit4_q ? fwd_q : rd4;

	// Arithmetic on next (b) and top (a), wrapped to the data width
	always_comb begin
		case (op)
			OP_ADD:  op_res = next_q + top_q;
			OP_SUB:  op_res = next_q - top_q;
			default: op_res = next_q * top_q;
		endcase
	end

	// Apply the token, then the optional emit
	always_comb begin
		a_top  = top_q;
		a_next = next_q;
		a_t2   = t2;
		cnt1   = count_q;
		err1   = err_q;
		if (op == OP_PUSH) begin
			if (full) begin
				if (err_q == ST_OK) begin
					err1 = ST_OVER;
				end
			end else begin
				a_top  = number;
				a_next = top_q;
				a_t2   = next_q;
				cnt1   = count_q + CNT_W'(1);
			end
		end else begin
			if (!has2) begin
				if (err_q == ST_OK) begin
					err1 = ST_UNDER;
				end
			end else begin
				a_top  = op_res;
				a_next = t2;
				a_t2   = t3;
				cnt1   = count_q - CNT_W'(1);
			end
		end

		emit_empty = (cnt1 == '0);
		top_n      = a_top;
		next_n     = a_next;
		cnt_n      = cnt1;
		if (end_of_expr && !emit_empty) begin
			top_n  = a_next;
			next_n = a_t2;
			cnt_n  = cnt1 - CNT_W'(1);
		end
		if (!accept) begin
			cnt_n = count_q;
		end
	end

	// Spill next into memory on a push that deepens the stack
	assign we          = accept && (op == OP_PUSH) && !full && has2 && !end_of_expr;
	assign waddr_full  = count_q - CNT_W'(2);
	assign waddr       = waddr_full[ADDR_W-1:0];

	// Prefetch the two entries below the next-cycle next
	assign raddr3_full = cnt_n - CNT_W'(3);
	assign raddr4_full = cnt_n - CNT_W'(4);
	assign raddr3      = raddr3_full[ADDR_W-1:0];
	assign raddr4      = raddr4_full[ADDR_W-1:0];

	pse_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (next_q),
		.raddr_a (raddr3),
		.rdata_a (rd3),
		.raddr_b (raddr4),
		.rdata_b (rd4)
	);

	// Advance count, error and forwarding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= ST_OK;
			hit3_q  <= 1'b0;
			hit4_q  <= 1'b0;
		end else begin
			count_q <= cnt_n;
			hit3_q  <= we && (waddr == raddr3);
			hit4_q  <= we && (waddr == raddr4);
			if (accept) begin
				err_q <= end_of_expr ? ST_OK : err1;
			end
		end
	end

	// Hold cached entries and the forwarded word
	always_ff @(posedge clk) begin
		fwd_q <= next_q;
		if (accept) begin
			top_q  <= top_n;
			next_q <= next_n;
		end
	end

	// Output register: load on an emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && end_of_expr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_expr) begin
			value_q  <= emit_empty ? '0 : a_top;
			status_q <= emit_empty ? ST_UNDER : err1;
		end
	end

	// Count stays within the stack depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// An emit always presents a word next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_expr |=> out_valid_q)
		else $error("emit did not raise out_valid");

	// An emit from an empty stack reports underflow with zero
	a_empty_emit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_expr && emit_empty |=> (status_q == ST_UNDER) && (value_q == '0))
		else $error("empty emit not reported as underflow");

	// Pending error clears after every emit
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_expr |=> err_q == ST_OK)
		else $error("error code not cleared after emit");

	// A push that is not full and does not end an expression grows the stack by exactly one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !end_of_expr && (op == OP_PUSH) && !full |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not advance count");

endmodule

`default_nettype wire

// ----- rtl/pse_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register both reads (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire
